// ----- design/ttay_pkg.sv -----
// shared constants and types for the taylor series tangent pipeline
package ttay_pkg;

    localparam int TERM_COUNT = 12;

    localparam int ANG_W   = 32;
    localparam int TAN_W   = 32;
    localparam int RED_SH  = 30;
    localparam int RED_W   = ANG_W + RED_SH;
    localparam int FRAC_SH = 28;
    localparam int X_W     = 30;
    localparam int X2_W    = 2 * X_W - FRAC_SH;
    localparam int TM_W    = 32;
    localparam int P_W     = 34;
    localparam int M_W     = P_W;
    localparam int RCP_SH  = P_W;
    localparam int D_W     = 11;
    localparam int ACC_W   = 36;
    localparam int MAG_W   = ACC_W;
    localparam int REM_W   = MAG_W + 1;
    localparam int TAN_SH  = 16;
    localparam int Q_W     = 2 * TAN_SH;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = Q_W / DIV_STEP;

    localparam logic [RED_W-1:0] TWO_PI_RED = 62'h6487ED5110B4612;
    localparam logic [RED_W-1:0] PI_RED     = 62'h3243F6A8885A309;
    localparam logic [TM_W-1:0]  ONE_Q28    = 32'h1000_0000;
    localparam logic [TAN_W-1:0] TAN_MAX    = 32'h7FFF_FFFF;
    localparam logic [TAN_W-1:0] TAN_MIN    = 32'h8000_0000;

    typedef struct packed {
        logic signed [ACC_W-1:0] s;
        logic signed [ACC_W-1:0] c;
        logic                    s_neg;
        logic [TM_W-1:0]         s_mag;
        logic                    c_neg;
        logic [TM_W-1:0]         c_mag;
        logic [X2_W-1:0]         x2;
    } t_series;

endpackage

// ----- design/tangent_taylor_series.sv -----
// top level: fixed-point tangent from taylor series sine and cosine
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_ready   i_angle (Q6.26)
//  output    out        o_valid / i_ready   o_tangent (Q16.16), o_overflow
//
// one angle per cycle when no result waits; an angle passes through the reduction,
// then each of the twelve series terms, then the quotient at two bits per stage
// the whole pipeline advances together and holds when a result waits
// synchronous active-low reset clears the valid bits only
module tangent_taylor_series import ttay_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [ANG_W-1:0] i_angle,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [TAN_W-1:0] o_tangent,
    output logic                    o_overflow
);

    logic             w_en;
    logic             w_v [TERM_COUNT+1];
    t_series          w_d [TERM_COUNT+1];
    logic [TAN_W-1:0] w_tan;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    ttay_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_angle (i_angle),
        .o_valid (w_v[0]),
        .o_data  (w_d[0])
    );

    for (genvar g = 0; g < TERM_COUNT; g++) begin : g_term
        localparam int DS = (2 * g + 2) * (2 * g + 3);
        localparam int DC = (2 * g + 1) * (2 * g + 2);
        localparam logic [M_W-1:0] RCP_S = M_W'((64'd1 << RCP_SH) / DS);
        localparam logic [M_W-1:0] RCP_C = M_W'((64'd1 << RCP_SH) / DC);
        ttay_term u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[g]),
            .i_data  (w_d[g]),
            .i_den_s (D_W'(DS)),
            .i_den_c (D_W'(DC)),
            .i_rcp_s (RCP_S),
            .i_rcp_c (RCP_C),
            .o_valid (w_v[g+1]),
            .o_data  (w_d[g+1])
        );
    end

    ttay_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_v[TERM_COUNT]),
        .i_data     (w_d[TERM_COUNT]),
        .o_valid    (o_valid),
        .o_tangent  (w_tan),
        .o_overflow (o_overflow)
    );

    assign o_tangent = signed'(w_tan);

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> (o_tangent == TAN_MAX || o_tangent == TAN_MIN))
        else $error("overflow flagged without a saturated tangent");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

// ----- design/ttay_reduce.sv -----
// angle reduction into minus pi to pi and squaring of the reduced angle
module ttay_reduce import ttay_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [ANG_W-1:0] i_angle,
    output logic             o_valid,
    output t_series          o_data
);

    localparam int NSUB = 3;

    logic [NSUB:0]    r_v;
    logic [RED_W-1:0] r_rem [NSUB+1];
    logic             r_neg [NSUB+1];
    logic             r_fv;
    logic             r_fneg;
    logic [X_W-1:0]   r_xmag;
    logic             r_qv;
    t_series          r_out;

    logic [ANG_W-1:0]   n_mag;
    logic               n_gt;
    logic [RED_W-1:0]   n_fold;
    logic [2*X_W-1:0]   n_sq;

    assign n_mag  = i_angle[ANG_W-1] ? (~i_angle + 1'b1) : i_angle;
    assign n_gt   = r_rem[NSUB] > PI_RED;
    assign n_fold = n_gt ? (TWO_PI_RED - r_rem[NSUB]) : r_rem[NSUB];
    assign n_sq   = r_xmag * r_xmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_fv <= 1'b0;
            r_qv <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[NSUB-1:0], i_valid};
            r_fv <= r_v[NSUB];
            r_qv <= r_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {n_mag, {RED_SH{1'b0}}};
            r_neg[0] <= i_angle[ANG_W-1];
        end
    end

    // restoring steps by four, two and one periods
    for (genvar k = 1; k <= NSUB; k++) begin : g_sub
        localparam logic [RED_W-1:0] STEP = TWO_PI_RED << (NSUB - k);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[k-1] >= STEP) begin
                    r_rem[k] <= r_rem[k-1] - STEP;
                end else begin
                    r_rem[k] <= r_rem[k-1];
                end
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fneg      <= r_neg[NSUB] ^ n_gt;
            r_xmag      <= n_fold[FRAC_SH+X_W-1:FRAC_SH];
            r_out.s     <= '0;
            r_out.c     <= '0;
            r_out.s_neg <= r_fneg;
            r_out.s_mag <= {{(TM_W-X_W){1'b0}}, r_xmag};
            r_out.c_neg <= 1'b0;
            r_out.c_mag <= ONE_Q28;
            r_out.x2    <= n_sq[FRAC_SH+X2_W-1:FRAC_SH];
        end
    end

    assign o_valid = r_qv;
    assign o_data  = r_out;

endmodule

// ----- design/ttay_term.sv -----
// one series term: accumulate, multiply by x squared, divide by the term denominator
module ttay_term import ttay_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  t_series        i_data,
    input  logic [D_W-1:0] i_den_s,
    input  logic [D_W-1:0] i_den_c,
    input  logic [M_W-1:0] i_rcp_s,
    input  logic [M_W-1:0] i_rcp_c,
    output logic           o_valid,
    output t_series        o_data
);

    logic [2:0] r_v;

    logic signed [ACC_W-1:0] r_a_s, r_a_c;
    logic                    r_a_sn, r_a_cn;
    logic [P_W-1:0]          r_a_ps, r_a_pc;
    logic [X2_W-1:0]         r_a_x2;

    logic signed [ACC_W-1:0] r_b_s, r_b_c;
    logic                    r_b_sn, r_b_cn;
    logic [P_W-1:0]          r_b_ps, r_b_pc;
    logic [P_W-1:0]          r_b_qs, r_b_qc;
    logic [X2_W-1:0]         r_b_x2;

    t_series r_out;

    logic signed [ACC_W-1:0] n_sv, n_cv, n_sx, n_cx;
    logic [TM_W+X2_W-1:0]    n_psp, n_pcp;
    logic [P_W+M_W-1:0]      n_qsp, n_qcp;
    logic [P_W+D_W-1:0]      n_dsp, n_dcp;
    logic [P_W-1:0]          n_rs, n_rc, n_qs, n_qc;

    always_comb begin
        n_sx  = signed'({{(ACC_W-TM_W){1'b0}}, i_data.s_mag});
        n_cx  = signed'({{(ACC_W-TM_W){1'b0}}, i_data.c_mag});
        n_sv  = i_data.s_neg ? -n_sx : n_sx;
        n_cv  = i_data.c_neg ? -n_cx : n_cx;
        n_psp = i_data.s_mag * i_data.x2;
        n_pcp = i_data.c_mag * i_data.x2;
        n_qsp = r_a_ps * i_rcp_s;
        n_qcp = r_a_pc * i_rcp_c;
        n_dsp = r_b_qs * i_den_s;
        n_dcp = r_b_qc * i_den_c;
        n_rs  = r_b_ps - n_dsp[P_W-1:0];
        n_rc  = r_b_pc - n_dcp[P_W-1:0];
        n_qs  = (n_rs >= {{(P_W-D_W){1'b0}}, i_den_s}) ? r_b_qs + 1'b1 : r_b_qs;
        n_qc  = (n_rc >= {{(P_W-D_W){1'b0}}, i_den_c}) ? r_b_qc + 1'b1 : r_b_qc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_s  <= i_data.s + n_sv;
            r_a_c  <= i_data.c + n_cv;
            r_a_sn <= i_data.s_neg;
            r_a_cn <= i_data.c_neg;
            r_a_ps <= n_psp[FRAC_SH+P_W-1:FRAC_SH];
            r_a_pc <= n_pcp[FRAC_SH+P_W-1:FRAC_SH];
            r_a_x2 <= i_data.x2;

            r_b_s  <= r_a_s;
            r_b_c  <= r_a_c;
            r_b_sn <= r_a_sn;
            r_b_cn <= r_a_cn;
            r_b_ps <= r_a_ps;
            r_b_pc <= r_a_pc;
            r_b_qs <= n_qsp[RCP_SH+P_W-1:RCP_SH];
            r_b_qc <= n_qcp[RCP_SH+P_W-1:RCP_SH];
            r_b_x2 <= r_a_x2;

            r_out.s     <= r_b_s;
            r_out.c     <= r_b_c;
            r_out.s_neg <= ~r_b_sn;
            r_out.c_neg <= ~r_b_cn;
            r_out.s_mag <= n_qs[TM_W-1:0];
            r_out.c_mag <= n_qc[TM_W-1:0];
            r_out.x2    <= r_b_x2;
        end
    end

    assign o_valid = r_v[2];
    assign o_data  = r_out;

endmodule

// ----- design/ttay_div.sv -----
// pipelined sine over cosine division with saturation
module ttay_div import ttay_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_series          i_data,
    output logic             o_valid,
    output logic [TAN_W-1:0] o_tangent,
    output logic             o_overflow
);

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   nb;
        logic [Q_W-1:0]   q;
        logic [MAG_W-1:0] mc;
        logic             sat;
        logic             cz;
        logic             tneg;
        logic             sneg;
    } t_div;

    t_div               r_st [DIV_STAGES+1];
    logic [DIV_STAGES:0] r_v;
    logic               r_ov;
    logic [TAN_W-1:0]   r_tan;
    logic               r_ovf;

    logic [MAG_W-1:0] n_ms, n_mc;
    t_div             n_p;
    t_div             n_l;
    logic [TAN_W-1:0] n_tan;
    logic             n_ovf;

    always_comb begin
        n_ms = i_data.s[ACC_W-1] ? (~i_data.s + 1'b1) : i_data.s;
        n_mc = i_data.c[ACC_W-1] ? (~i_data.c + 1'b1) : i_data.c;
        n_p.rem  = {{(REM_W-MAG_W+TAN_SH){1'b0}}, n_ms[MAG_W-1:TAN_SH]};
        n_p.nb   = {n_ms[TAN_SH-1:0], {TAN_SH{1'b0}}};
        n_p.q    = '0;
        n_p.mc   = n_mc;
        n_p.sat  = {{TAN_SH{1'b0}}, n_ms} >= {n_mc, {TAN_SH{1'b0}}};
        n_p.cz   = (i_data.c == '0);
        n_p.tneg = i_data.s[ACC_W-1] ^ i_data.c[ACC_W-1];
        n_p.sneg = i_data.s[ACC_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[DIV_STAGES-1:0], i_valid};
            r_ov <= r_v[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_p;
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        t_div             n_st;
        logic [REM_W-1:0] n_t;
        always_comb begin
            n_st = r_st[k-1];
            n_t  = '0;
            for (int j = 0; j < DIV_STEP; j++) begin
                n_t     = {n_st.rem[REM_W-2:0], n_st.nb[Q_W-1]};
                n_st.nb = {n_st.nb[Q_W-2:0], 1'b0};
                if (n_t >= {1'b0, n_st.mc}) begin
                    n_st.rem = n_t - {1'b0, n_st.mc};
                    n_st.q   = {n_st.q[Q_W-2:0], 1'b1};
                end else begin
                    n_st.rem = n_t;
                    n_st.q   = {n_st.q[Q_W-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    always_comb begin
        n_l = r_st[DIV_STAGES];
        if (n_l.cz) begin
            n_tan = n_l.sneg ? TAN_MIN : TAN_MAX;
            n_ovf = 1'b1;
        end else if (n_l.sat) begin
            n_tan = n_l.tneg ? TAN_MIN : TAN_MAX;
            n_ovf = 1'b1;
        end else if (n_l.tneg) begin
            if (n_l.q > TAN_MIN) begin
                n_tan = TAN_MIN;
                n_ovf = 1'b1;
            end else begin
                n_tan = ~n_l.q + 1'b1;
                n_ovf = 1'b0;
            end
        end else begin
            if (n_l.q > TAN_MAX) begin
                n_tan = TAN_MAX;
                n_ovf = 1'b1;
            end else begin
                n_tan = n_l.q;
                n_ovf = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tan <= n_tan;
            r_ovf <= n_ovf;
        end
    end

    assign o_valid    = r_ov;
    assign o_tangent  = r_tan;
    assign o_overflow = r_ovf;

endmodule
